// ===== rtl/core/swrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swrs_pkg;

  // Event codes carried in the operation field
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_REPLY = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Reply byte codes
  localparam logic [7:0] CODE_ACK  = 8'd1;
  localparam logic [7:0] CODE_NACK = 8'd2;
  localparam logic [7:0] CODE_END  = 8'd3;

  // Configuration register indexes (word address bits)
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] REG_START_BYTE  = 2'd1;
  localparam logic [1:0] REG_IS_MASTER   = 2'd2;

  // Configuration reset values
  localparam logic [2:0] RETRY_LIMIT_RST = 3'd4;
  localparam logic [7:0] START_BYTE_RST  = 8'd60;
  localparam logic       IS_MASTER_RST   = 1'b0;

  typedef struct packed {
    logic [2:0] retry_limit;
    logic [7:0] start_byte;
    logic       is_master;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic       rx_error;
    logic [7:0] next_byte;
    logic       peer_done;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic       tx_ninth;
    logic [7:0] tx_byte;
    logic       next_taken;
    logic       show_frame;
    logic       link_lost;
  } out_item_t;

  typedef struct packed {
    logic [7:0] held_byte;
    logic       held_ninth;
    logic       timer_armed;
    logic [2:0] timeout_count;
  } arq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/swrs_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swrs_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output swrs_pkg::cfg_t     cfg_o
);

  swrs_pkg::cfg_t cfg_q;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit <= swrs_pkg::RETRY_LIMIT_RST;
      cfg_q.start_byte  <= swrs_pkg::START_BYTE_RST;
      cfg_q.is_master   <= swrs_pkg::IS_MASTER_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        swrs_pkg::REG_RETRY_LIMIT: cfg_q.retry_limit <= pwdata[2:0];
        swrs_pkg::REG_START_BYTE:  cfg_q.start_byte  <= pwdata[7:0];
        swrs_pkg::REG_IS_MASTER:   cfg_q.is_master   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux, unmapped addresses read as zero
  always_comb begin
    case (paddr[3:2])
      swrs_pkg::REG_RETRY_LIMIT: prdata = {29'd0, cfg_q.retry_limit};
      swrs_pkg::REG_START_BYTE:  prdata = {24'd0, cfg_q.start_byte};
      swrs_pkg::REG_IS_MASTER:   prdata = {31'd0, cfg_q.is_master};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/swrs_step_logic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swrs_step_logic (
  input  wire swrs_pkg::cfg_t       cfg_i,
  input  wire swrs_pkg::in_item_t   item_i,
  input  wire swrs_pkg::arq_state_t state_i,
  output swrs_pkg::arq_state_t      state_o,
  output swrs_pkg::out_item_t       res_o
);

  logic [2:0] cnt_inc;

  assign cnt_inc = state_i.timeout_count + 3'd1;

  // One event: next protocol state and the frame to send, if any
  always_comb begin
    state_o = state_i;
    res_o   = '0;
    case (item_i.operation)
      swrs_pkg::OP_START: begin
        state_o.timeout_count = 3'd0;
        state_o.timer_armed   = 1'b1;
        res_o.tx_valid        = 1'b1;
        res_o.tx_ninth        = 1'b1;
        res_o.tx_byte         = cfg_i.start_byte;
      end
      swrs_pkg::OP_REPLY: begin
        state_o.timer_armed   = 1'b0;
        state_o.timeout_count = 3'd0;
        if (item_i.rx_error) begin
          // bad frame: answer with a NACK control frame, timer stays off
          res_o.tx_valid = 1'b1;
          res_o.tx_ninth = 1'b1;
          res_o.tx_byte  = swrs_pkg::CODE_NACK;
        end else if (item_i.rx_byte == swrs_pkg::CODE_ACK) begin
          res_o.tx_valid      = 1'b1;
          res_o.tx_byte       = item_i.next_byte;
          res_o.next_taken    = 1'b1;
          state_o.timer_armed = 1'b1;
        end else if (item_i.rx_byte == swrs_pkg::CODE_NACK) begin
          res_o.tx_valid      = 1'b1;
          res_o.tx_byte       = state_i.held_byte;
          state_o.timer_armed = 1'b1;
        end else if (item_i.rx_byte == swrs_pkg::CODE_END) begin
          res_o.show_frame = 1'b1;
        end
      end
      swrs_pkg::OP_TICK: begin
        if (state_i.timer_armed) begin
          if (cnt_inc >= cfg_i.retry_limit) begin
            state_o.timer_armed   = 1'b0;
            state_o.timeout_count = 3'd0;
            res_o.link_lost       = 1'b1;
            res_o.show_frame      = item_i.peer_done | cfg_i.is_master;
          end else begin
            // timeout: repeat the held frame and keep the timer running
            state_o.timeout_count = cnt_inc;
            res_o.tx_valid        = 1'b1;
            res_o.tx_ninth        = state_i.held_ninth;
            res_o.tx_byte         = state_i.held_byte;
          end
        end
      end
      default: ;
    endcase
    // every frame sent becomes the held frame
    if (res_o.tx_valid) begin
      state_o.held_byte  = res_o.tx_byte;
      state_o.held_ninth = res_o.tx_ninth;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stop_and_wait_retry_sender.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stop-and-wait retry sender for 9-bit UART frames.
// Input stream (s_axis): one event per transaction - start, reply received
// or timer tick, selected by tuser. Output stream (m_axis): exactly one
// result per event, holding the frame to transmit (if any) and the
// next_taken, show_frame and link_lost flags.
// Configuration through the APB port: retry_limit at 0x0, start_byte at 0x4,
// is_master at 0x8. Write only while no event is in flight.
// An accepted event is registered in the input register, decoded and
// registered again in the result register, which drives m_axis.
// Throughput: one event per cycle while m_axis_tready is not held low; the
// protocol state is a handful of flip-flops updated by a single decode stage
// between the input register and the result register.
// Reset clears the held frame, the timer and the timeout count, empties
// both pipeline registers and restores the register defaults.
// When the receiver stalls, the result register holds its transaction, the
// input register takes one more event if empty and then s_axis_tready goes low.
module stop_and_wait_retry_sender (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // s_axis
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // rx_byte[7:0], next_byte[15:8], peer_done[16]
  input  wire logic [2:0]  s_axis_tuser,  // operation[1:0], rx_error[2]
  // m_axis
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // tx_valid[0], tx_ninth[1], tx_byte[9:2],
                                          // next_taken[10], show_frame[11], link_lost[12]
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  swrs_pkg::cfg_t       cfg;
  swrs_pkg::in_item_t   in_q;
  swrs_pkg::out_item_t  out_q;
  swrs_pkg::out_item_t  res;
  swrs_pkg::arq_state_t state_q;
  swrs_pkg::arq_state_t state_d;
  logic                 in_valid_q;
  logic                 in_valid_d;
  logic                 out_valid_q;
  logic                 out_valid_d;
  logic                 out_ready;
  logic                 in_ready;
  logic                 accept;
  logic                 advance;

  swrs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swrs_step_logic u_step (
    .cfg_i   (cfg),
    .item_i  (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // Handshake: each stage frees up when its content moves on
  assign out_ready   = ~out_valid_q | m_axis_tready;
  assign in_ready    = ~in_valid_q | out_ready;
  assign accept      = s_axis_tvalid & in_ready;
  assign advance     = in_valid_q & out_ready;
  assign in_valid_d  = accept | (in_valid_q & ~out_ready);
  assign out_valid_d = advance | (out_valid_q & ~m_axis_tready);

  assign s_axis_tready = in_ready;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.operation <= s_axis_tuser[1:0];
      in_q.rx_error  <= s_axis_tuser[2];
      in_q.rx_byte   <= s_axis_tdata[7:0];
      in_q.next_byte <= s_axis_tdata[15:8];
      in_q.peer_done <= s_axis_tdata[16];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q.link_lost, out_q.show_frame, out_q.next_taken,
                          out_q.tx_byte, out_q.tx_ninth, out_q.tx_valid};

  // A lost link never sends a frame in the same result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.link_lost) |-> !out_q.tx_valid)
    else $error("link_lost together with a transmitted frame");

  // A consumed data byte is always sent as a data frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.next_taken) |-> (out_q.tx_valid && !out_q.tx_ninth))
    else $error("next_taken without a data frame");

  // Every frame sent becomes the held frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.tx_valid) |=>
      (state_q.held_byte == $past(res.tx_byte) && state_q.held_ninth == $past(res.tx_ninth)))
    else $error("held frame not updated on transmit");

  // After a lost link the timer is stopped and the count cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.link_lost) |=> (!state_q.timer_armed && state_q.timeout_count == 3'd0))
    else $error("timer still running after link loss");

endmodule

`default_nettype wire
